// ===== hw/rtl/ial_pkg.sv =====
package ial_pkg;

  localparam int Capacity  = 64;
  localparam int DataWidth = 32;
  localparam int AddrWidth = $clog2(Capacity);
  localparam int CountWidth = AddrWidth + 1;
  localparam int TotalWidth = 38;

  typedef enum logic [3:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_INSERT     = 4'd2,
    OP_REMOVE     = 4'd3,
    OP_POP_BACK   = 4'd4,
    OP_POP_FRONT  = 4'd5,
    OP_READ       = 4'd6,
    OP_FRONT      = 4'd7,
    OP_BACK       = 4'd8,
    OP_FIND       = 4'd9,
    OP_SORT       = 4'd10,
    OP_UNIQUE     = 4'd11,
    OP_MIN        = 4'd12,
    OP_MAX        = 4'd13,
    OP_SUM        = 4'd14,
    OP_NONE       = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT_UP_RD,
    S_SHIFT_UP_WR,
    S_SHIFT_DN_RD,
    S_SHIFT_DN_WR,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SORT_RD0,
    S_SORT_RD1,
    S_SORT_EV,
    S_SORT_WR,
    S_UNI_RD,
    S_UNI_CMP,
    S_DONE
  } state_t;

  // Memory access request from the sequencer.
  typedef struct packed {
    logic                 we;
    logic [AddrWidth-1:0] waddr;
    logic [DataWidth-1:0] wdata;
    logic [AddrWidth-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hw/rtl/ial_if.sv =====
interface ial_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic [ial_pkg::CountWidth-1:0] position;
  logic signed [ial_pkg::DataWidth-1:0] item;
  logic        descending;
  modport source(output valid, op, position, item, descending, input ready);
  modport sink(input valid, op, position, item, descending, output ready);
endinterface

interface ial_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [ial_pkg::DataWidth-1:0] read_value;
  logic [ial_pkg::AddrWidth-1:0]  found_index;
  logic [ial_pkg::CountWidth-1:0] entry_count;
  logic signed [ial_pkg::TotalWidth-1:0] total;
  modport source(output valid, status, read_value, found_index, entry_count, total,
                 input ready);
  modport sink(input valid, status, read_value, found_index, entry_count, total,
               output ready);
endinterface

// ===== hw/rtl/ial_mem.sv =====
module ial_mem (
  input  logic                                 clk,
  input  ial_pkg::mem_req_t                    req,
  output logic signed [ial_pkg::DataWidth-1:0] rdata
);

  logic [ial_pkg::DataWidth-1:0] mem [ial_pkg::Capacity];

  // Write one word, read one word registered.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== hw/rtl/ial_seq.sv =====
module ial_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  ial_in_if.sink                               in_ch,
  ial_out_if.source                            out_ch,
  output ial_pkg::mem_req_t                    req,
  input  logic signed [ial_pkg::DataWidth-1:0] rdata
);

  localparam int AW = ial_pkg::AddrWidth;
  localparam int CW = ial_pkg::CountWidth;
  localparam int DW = ial_pkg::DataWidth;
  localparam int TW = ial_pkg::TotalWidth;

  ial_pkg::state_t state, state_next;

  ial_pkg::op_t    op;
  logic signed [DW-1:0] item;
  logic            desc;
  logic [CW-1:0]   fill, fill_next;
  logic [CW-1:0]   idx, idx_next;     // walking index
  logic [CW-1:0]   lim, lim_next;     // sort pass limit / dedup kept count
  logic [CW-1:0]   jdx, jdx_next;     // dedup inner index
  logic signed [DW-1:0] acc, acc_next; // held word / min / max / cand
  logic signed [TW-1:0] sum, sum_next;

  ial_pkg::status_t st, st_next;
  logic signed [DW-1:0] rv, rv_next;
  logic [AW-1:0]   fidx, fidx_next;
  logic            ovalid, ovalid_next;

  logic signed [DW-1:0] held;   // first word of a sort pair
  logic signed [DW-1:0] held_next;

  logic take;
  logic less, greater, swap;

  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ial_pkg::S_IDLE) && !ovalid;

  // Shared compare unit.
  always_comb begin
    less    = rdata < acc;
    greater = rdata > acc;
    swap    = desc ? (held < rdata) : (held > rdata);
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ial_pkg::S_IDLE;
      fill   <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      ovalid <= ovalid_next;
    end
    if (take) begin
      op   <= ial_pkg::op_t'(in_ch.op);
      item <= in_ch.item;
      desc <= in_ch.descending;
    end
    idx  <= idx_next;
    lim  <= lim_next;
    jdx  <= jdx_next;
    acc  <= acc_next;
    sum  <= sum_next;
    held <= held_next;
    st   <= st_next;
    rv   <= rv_next;
    fidx <= fidx_next;
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.status      = st;
  assign out_ch.read_value  = rv;
  assign out_ch.found_index = fidx;
  assign out_ch.entry_count = fill;
  assign out_ch.total       = sum;

  // Next state and datapath control.
  always_comb begin
    state_next  = state;
    fill_next   = fill;
    ovalid_next = ovalid;
    idx_next    = idx;
    lim_next    = lim;
    jdx_next    = jdx;
    acc_next    = acc;
    sum_next    = sum;
    held_next   = held;
    st_next     = st;
    rv_next     = rv;
    fidx_next   = fidx;
    req.we      = 1'b0;
    req.waddr   = idx[AW-1:0];
    req.wdata   = acc;
    req.raddr   = idx[AW-1:0];

    if (ovalid && out_ch.ready) begin
      ovalid_next = 1'b0;
    end

    case (state)
      ial_pkg::S_IDLE: begin
        if (take) begin
          st_next   = ial_pkg::ST_OK;
          rv_next   = '0;
          fidx_next = '0;
          sum_next  = '0;
          acc_next  = in_ch.item;
          state_next = ial_pkg::S_DONE;
          case (ial_pkg::op_t'(in_ch.op))
            ial_pkg::OP_PUSH_BACK, ial_pkg::OP_PUSH_FRONT, ial_pkg::OP_INSERT: begin
              if (in_ch.op == ial_pkg::OP_INSERT && in_ch.position > fill) begin
                st_next = ial_pkg::ST_RANGE;
              end else if (fill >= CW'(ial_pkg::Capacity)) begin
                st_next = ial_pkg::ST_FULL;
              end else begin
                // Target slot kept in lim; shift from the top down.
                case (ial_pkg::op_t'(in_ch.op))
                  ial_pkg::OP_PUSH_BACK:  lim_next = fill;
                  ial_pkg::OP_PUSH_FRONT: lim_next = '0;
                  default:                lim_next = in_ch.position;
                endcase
                idx_next   = fill;
                state_next = ial_pkg::S_SHIFT_UP_RD;
              end
            end
            ial_pkg::OP_REMOVE, ial_pkg::OP_POP_FRONT: begin
              if (in_ch.op == ial_pkg::OP_POP_FRONT && fill == '0) begin
                st_next = ial_pkg::ST_EMPTY;
              end else if (in_ch.op == ial_pkg::OP_REMOVE && in_ch.position >= fill) begin
                st_next = ial_pkg::ST_RANGE;
              end else begin
                idx_next = (in_ch.op == ial_pkg::OP_REMOVE) ? in_ch.position : '0;
                state_next = ial_pkg::S_SHIFT_DN_RD;
              end
            end
            ial_pkg::OP_POP_BACK: begin
              if (fill == '0) st_next = ial_pkg::ST_EMPTY;
              else fill_next = fill - 1'b1;
            end
            ial_pkg::OP_READ, ial_pkg::OP_FRONT, ial_pkg::OP_BACK: begin
              if (in_ch.op == ial_pkg::OP_READ && in_ch.position >= fill) begin
                st_next = ial_pkg::ST_RANGE;
              end else if (in_ch.op != ial_pkg::OP_READ && fill == '0) begin
                st_next = ial_pkg::ST_EMPTY;
              end else begin
                case (ial_pkg::op_t'(in_ch.op))
                  ial_pkg::OP_READ:  idx_next = in_ch.position;
                  ial_pkg::OP_FRONT: idx_next = '0;
                  default:           idx_next = fill - 1'b1;
                endcase
                lim_next   = '0;
                state_next = ial_pkg::S_SCAN_RD;
              end
            end
            ial_pkg::OP_FIND, ial_pkg::OP_MIN, ial_pkg::OP_MAX, ial_pkg::OP_SUM: begin
              if (in_ch.op == ial_pkg::OP_FIND) st_next = ial_pkg::ST_MISSING;
              if (fill == '0) begin
                if (in_ch.op != ial_pkg::OP_FIND) st_next = ial_pkg::ST_EMPTY;
              end else begin
                idx_next   = '0;
                state_next = ial_pkg::S_SCAN_RD;
              end
            end
            ial_pkg::OP_SORT: begin
              if (fill >= CW'(2)) begin
                lim_next   = fill - 1'b1;
                idx_next   = '0;
                state_next = ial_pkg::S_SORT_RD0;
              end
            end
            ial_pkg::OP_UNIQUE: begin
              if (fill >= CW'(2)) begin
                lim_next   = CW'(1);
                idx_next   = CW'(1);
                jdx_next   = '0;
                state_next = ial_pkg::S_UNI_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // Move entries up one slot, top first, then drop the item in.
      ial_pkg::S_SHIFT_UP_RD: begin
        if (idx == lim) begin
          req.we    = 1'b1;
          req.waddr = lim[AW-1:0];
          req.wdata = item;
          fill_next = fill + 1'b1;
          state_next = ial_pkg::S_DONE;
        end else begin
          req.raddr  = AW'(idx - 1'b1);
          state_next = ial_pkg::S_SHIFT_UP_WR;
        end
      end
      ial_pkg::S_SHIFT_UP_WR: begin
        req.we     = 1'b1;
        req.wdata  = rdata;
        idx_next   = idx - 1'b1;
        state_next = ial_pkg::S_SHIFT_UP_RD;
      end

      // Move entries down one slot, closing a gap.
      ial_pkg::S_SHIFT_DN_RD: begin
        if (idx + 1'b1 >= fill) begin
          fill_next  = fill - 1'b1;
          state_next = ial_pkg::S_DONE;
        end else begin
          req.raddr  = AW'(idx + 1'b1);
          state_next = ial_pkg::S_SHIFT_DN_WR;
        end
      end
      ial_pkg::S_SHIFT_DN_WR: begin
        req.we     = 1'b1;
        req.wdata  = rdata;
        idx_next   = idx + 1'b1;
        state_next = ial_pkg::S_SHIFT_DN_RD;
      end

      // Scan: read, front, back, find, min, max and sum share this walk.
      ial_pkg::S_SCAN_RD: begin
        state_next = ial_pkg::S_SCAN_EV;
      end
      ial_pkg::S_SCAN_EV: begin
        idx_next   = idx + 1'b1;
        req.raddr  = AW'(idx + 1'b1);
        state_next = ial_pkg::S_SCAN_RD;
        case (op)
          ial_pkg::OP_READ, ial_pkg::OP_FRONT, ial_pkg::OP_BACK: begin
            rv_next    = rdata;
            state_next = ial_pkg::S_DONE;
          end
          ial_pkg::OP_FIND: begin
            if (rdata == item) begin
              st_next    = ial_pkg::ST_OK;
              fidx_next  = idx[AW-1:0];
              state_next = ial_pkg::S_DONE;
            end
          end
          ial_pkg::OP_MIN, ial_pkg::OP_MAX: begin
            if (idx == '0 || (op == ial_pkg::OP_MIN ? less : greater)) begin
              acc_next = rdata;
              rv_next  = rdata;
            end
          end
          default: begin
            sum_next = sum + TW'(rdata);
          end
        endcase
        if (op != ial_pkg::OP_READ && op != ial_pkg::OP_FRONT && op != ial_pkg::OP_BACK
            && idx + 1'b1 >= fill) begin
          state_next = ial_pkg::S_DONE;
        end
      end

      // Bubble sort: compare adjacent pair, swap through memory.
      ial_pkg::S_SORT_RD0: begin
        req.raddr  = idx[AW-1:0];
        state_next = ial_pkg::S_SORT_RD1;
      end
      ial_pkg::S_SORT_RD1: begin
        held_next  = rdata;
        req.raddr  = AW'(idx + 1'b1);
        state_next = ial_pkg::S_SORT_EV;
        if (idx != '0) begin
          // Carry forward the word left in the upper slot of the previous pair.
          held_next = acc;
        end
      end
      ial_pkg::S_SORT_EV: begin
        state_next = ial_pkg::S_SORT_WR;
        if (swap) begin
          req.we    = 1'b1;
          req.waddr = idx[AW-1:0];
          req.wdata = rdata;
          acc_next  = held;
        end else begin
          acc_next  = rdata;
        end
      end
      ial_pkg::S_SORT_WR: begin
        req.we    = 1'b1;
        req.waddr = AW'(idx + 1'b1);
        req.wdata = acc;
        if (idx + 1'b1 >= lim) begin
          idx_next = '0;
          lim_next = lim - 1'b1;
          state_next = (lim == CW'(1)) ? ial_pkg::S_DONE : ial_pkg::S_SORT_RD0;
        end else begin
          idx_next = idx + 1'b1;
          req.raddr = AW'(idx + 1'b1);
          state_next = ial_pkg::S_SORT_RD1;
        end
      end

      // Dedup: idx walks the input, jdx walks the kept prefix.
      ial_pkg::S_UNI_RD: begin
        req.raddr  = idx[AW-1:0];
        jdx_next   = '0;
        state_next = ial_pkg::S_UNI_CMP;
      end
      ial_pkg::S_UNI_CMP: begin
        req.raddr = jdx[AW-1:0];
        if (jdx == '0) begin
          acc_next = rdata;       // candidate word
          jdx_next = CW'(1);
        end else begin
          jdx_next = jdx + 1'b1;
        end
        if (jdx != '0 && (rdata == acc || jdx == lim)) begin
          if (!(rdata == acc)) begin
            req.we    = 1'b1;
            req.waddr = lim[AW-1:0];
            req.wdata = acc;
            lim_next  = lim + 1'b1;
          end
          idx_next = idx + 1'b1;
          if (idx + 1'b1 >= fill) begin
            fill_next  = (rdata == acc) ? lim : lim + 1'b1;
            state_next = ial_pkg::S_DONE;
          end else begin
            req.raddr  = AW'(idx + 1'b1);
            state_next = ial_pkg::S_UNI_RD;
          end
        end
      end

      ial_pkg::S_DONE: begin
        ovalid_next = 1'b1;
        state_next  = ial_pkg::S_IDLE;
      end

      default: state_next = ial_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/indexed_array_list_engine.sv =====
// Channel | Dir | Payload
// in_ch   | in  | op, position, item, descending
// out_ch  | out | status, read_value, found_index, entry_count, total
//
// One command at a time through a word memory with one write port and one
// registered read port; shifts and scans read each entry touched and then
// write or evaluate it, sort swaps adjacent pairs through memory and unique
// compares each word against the kept prefix.
// Reset (rst, synchronous) empties the list; memory contents are not cleared.
// in_ch.ready stays low while a command runs or a result waits on out_ch.
module indexed_array_list_engine (
  input logic       clk,
  input logic       rst,
  ial_in_if.sink    in_ch,
  ial_out_if.source out_ch
);

  ial_pkg::mem_req_t                    req;
  logic signed [ial_pkg::DataWidth-1:0] rdata;

  ial_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .req    (req),
    .rdata  (rdata)
  );

  ial_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

// ===== tb/ial_list_checker.sv =====
module ial_list_checker
  import ial_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ial_in_if    in_mon,
  ial_out_if   out_mon,
  output int   fail_count,
  output int   waiting_results
);

  typedef struct {
    status_t                status;
    logic signed [31:0]     read_value;
    logic [5:0]             found_index;
    logic [6:0]             entry_count;
    logic signed [37:0]     total;
  } list_result_t;

  // Shadow copy of the list
  logic signed [DataWidth-1:0] shadow_words [Capacity];
  int                          shadow_len;
  list_result_t                pending_results [$];

  function automatic list_result_t apply_command(op_t op, logic [6:0] pos,
                                                 logic signed [31:0] val, logic desc);
    list_result_t                r;
    int                          at;
    int                          kept;
    bit                          dup;
    bit                          swap;
    logic signed [DataWidth-1:0] t;
    r.status      = ST_OK;
    r.read_value  = '0;
    r.found_index = '0;
    r.total       = '0;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (op == OP_INSERT && pos > shadow_len) r.status = ST_RANGE;
        else if (shadow_len >= Capacity) r.status = ST_FULL;
        else begin
          at = (op == OP_PUSH_BACK) ? shadow_len : (op == OP_PUSH_FRONT) ? 0 : int'(pos);
          for (int i = shadow_len; i > at; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[at] = val;
          shadow_len++;
        end
      end
      OP_REMOVE, OP_POP_FRONT: begin
        at = (op == OP_REMOVE) ? int'(pos) : 0;
        if (op == OP_REMOVE && pos >= shadow_len) r.status = ST_RANGE;
        else if (shadow_len == 0) r.status = ST_EMPTY;
        else begin
          for (int i = at; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else shadow_len--;
      end
      OP_READ: begin
        if (pos >= shadow_len) r.status = ST_RANGE;
        else r.read_value = shadow_words[pos];
      end
      OP_FRONT, OP_BACK: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else r.read_value = shadow_words[(op == OP_FRONT) ? 0 : shadow_len - 1];
      end
      OP_FIND: begin
        r.status = ST_MISSING;
        for (int i = 0; i < shadow_len; i++)
          if (shadow_words[i] == val) begin
            r.status      = ST_OK;
            r.found_index = 6'(i);
            break;
          end
      end
      OP_SORT: begin
        for (int i = 0; i + 1 < shadow_len; i++)
          for (int j = 0; j + 1 < shadow_len - i; j++) begin
            swap = desc ? (shadow_words[j] < shadow_words[j+1])
                        : (shadow_words[j] > shadow_words[j+1]);
            if (swap) begin
              t                 = shadow_words[j];
              shadow_words[j]   = shadow_words[j+1];
              shadow_words[j+1] = t;
            end
          end
      end
      OP_UNIQUE: begin
        if (shadow_len >= 2) begin
          kept = 1;
          for (int i = 1; i < shadow_len; i++) begin
            dup = 1'b0;
            for (int j = 0; j < kept; j++)
              if (shadow_words[i] == shadow_words[j]) dup = 1'b1;
            if (!dup) begin
              shadow_words[kept] = shadow_words[i];
              kept++;
            end
          end
          shadow_len = kept;
        end
      end
      OP_MIN, OP_MAX: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else begin
          r.read_value = shadow_words[0];
          for (int i = 1; i < shadow_len; i++)
            if (op == OP_MIN ? shadow_words[i] < r.read_value
                             : shadow_words[i] > r.read_value)
              r.read_value = shadow_words[i];
        end
      end
      OP_SUM: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else for (int i = 0; i < shadow_len; i++) r.total += 38'(shadow_words[i]);
      end
      default: ;
    endcase
    r.entry_count = 7'(shadow_len);
    return r;
  endfunction

  // Compare each result transaction, then predict each command transaction
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      shadow_len = 0;
      fail_count <= 0;
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (out_mon.status !== want.status ||
              out_mon.read_value !== want.read_value ||
              out_mon.found_index !== want.found_index ||
              out_mon.entry_count !== want.entry_count ||
              out_mon.total !== want.total)
            fail_count <= fail_count + 1;
          if (out_mon.status !== want.status)
            $error("status: expected %0d, got %0d", want.status, out_mon.status);
          if (out_mon.read_value !== want.read_value)
            $error("read_value: expected %0d, got %0d", want.read_value, out_mon.read_value);
          if (out_mon.found_index !== want.found_index)
            $error("found_index: expected %0d, got %0d", want.found_index,
                   out_mon.found_index);
          if (out_mon.entry_count !== want.entry_count)
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_mon.entry_count);
          if (out_mon.total !== want.total)
            $error("total: expected %0d, got %0d", want.total, out_mon.total);
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_results.insert(pending_results.size(),
                               apply_command(op_t'(in_mon.op), in_mon.position,
                                             in_mon.item, in_mon.descending));
    end
    waiting_results <= pending_results.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import ial_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   waiting_results;
  int   commands_sent = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  bit   rx_hold = 1'b0;
  int   rx_wait;

  ial_in_if  in_ch ();
  ial_out_if out_ch ();

  indexed_array_list_engine dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  ial_list_checker checker_i (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .waiting_results(waiting_results)
  );

  always #5 clk = ~clk;

  // Give up after a generous bound
  initial begin
    #60_000_000;
    $display("indexed_array_list_engine test failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= 0;
    end else if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait      <= rx_wait - 1;
      out_ch.ready <= 1'b0;
    end else if (out_ch.ready && out_ch.valid) begin
      if (rx_quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        rx_wait      <= $urandom_range(0, 4);
        out_ch.ready <= 1'b0;
      end
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    wait (commands_sent >= 300);
    rx_hold = 1'b1;
    repeat (600) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Offer one command transaction and hold it until accepted
  task automatic send(op_t op, logic [6:0] pos = '0, logic signed [31:0] val = '0,
                      logic desc = 1'b0);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.position   <= pos;
    in_ch.item       <= val;
    in_ch.descending <= desc;
    do @(posedge clk); while (!in_ch.ready);
    commands_sent++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom;
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  function automatic logic [6:0] pick_position();
    return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 64))
                                       : 7'($urandom_range(0, 8));
  endfunction

  // Grow to capacity, hit the full cases, sum, sort, read and dedup, then drain
  task automatic fill_and_drain(int kind);
    logic signed [31:0] v;
    for (int i = 0; i < Capacity + 2; i++) begin
      v = (kind == 0) ? 32'sh7fff_ffff : (kind == 1) ? 32'sh8000_0000 : pick_value();
      send(OP_PUSH_BACK, '0, v);
    end
    send(OP_PUSH_FRONT, '0, 32'sd1);
    send(OP_INSERT, 7'd64, 32'sd1);
    send(OP_INSERT, 7'd3, 32'sd1);
    send(OP_SUM);
    send(OP_SORT, '0, '0, 1'b1);
    send(OP_SORT, '0, '0, 1'b0);
    send(OP_READ, 7'd63);
    send(OP_READ, 7'd64);
    send(OP_UNIQUE);
    for (int i = 0; i < Capacity; i++)
      send(($urandom_range(0, 1) == 1) ? OP_POP_BACK : OP_POP_FRONT);
  endtask

  function automatic op_t pick_op(int bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_SORT;
    if (r < 6) return OP_UNIQUE;
    if (r < 8) return OP_NONE;
    if (bias == 0 && r < 60) return op_t'($urandom_range(0, 2));
    if (bias == 2 && r < 50) return op_t'($urandom_range(3, 5));
    return op_t'($urandom_range(0, 14));
  endfunction

  initial begin
    int bias;
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_NONE;
    in_ch.position   <= '0;
    in_ch.item       <= '0;
    in_ch.descending <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Empty list corner cases
    send(OP_POP_BACK);
    send(OP_POP_FRONT);
    send(OP_FRONT);
    send(OP_BACK);
    send(OP_MIN);
    send(OP_MAX);
    send(OP_SUM);
    send(OP_FIND, '0, 32'sd0);
    send(OP_REMOVE, 7'd0);
    send(OP_READ, 7'd0);
    send(OP_INSERT, 7'd1, 32'sd5);
    send(OP_SORT);
    send(OP_UNIQUE);
    send(OP_NONE);
    // Short list, then insert, find, sort, dedup, sum and remove on a few entries
    send(OP_PUSH_BACK, '0, 32'sh7fff_ffff);
    send(OP_SORT, '0, '0, 1'b1);
    send(OP_PUSH_FRONT, '0, 32'sh8000_0000);
    send(OP_INSERT, 7'd1, 32'sd7);
    send(OP_INSERT, 7'd3, 32'sd7);
    send(OP_FIND, '0, 32'sd7);
    send(OP_FIND, '0, -32'sd1);
    send(OP_SORT, '0, '0, 1'b1);
    send(OP_UNIQUE);
    send(OP_SUM);
    send(OP_REMOVE, 7'd1);

    fill_and_drain(0);
    fill_and_drain(1);

    // Random segments with changing growth bias and idle behavior
    for (int seg = 0; seg < 11; seg++) begin
      bias     = $urandom_range(0, 2);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 80; i++)
        send(pick_op(bias), pick_position(), pick_value(), 1'($urandom_range(0, 1)));
      if (seg == 6) fill_and_drain(2);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    wait (waiting_results == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("indexed_array_list_engine test passed");
    else
      $display("indexed_array_list_engine test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ial_pkg.sv
hw/rtl/ial_if.sv
hw/rtl/ial_mem.sv
hw/rtl/ial_seq.sv
hw/rtl/indexed_array_list_engine.sv
tb/ial_list_checker.sv
tb/tb.sv
